@@ hdl/bde_pkg.sv @@
// bucket directory engine: shared types, codes and constants
// used by bde_ctrl, bde_datapath and bucket_directory_engine_top
// no dependencies
package bde_pkg;

	// directory size default
	localparam int SLOT_COUNT_DEFAULT = 256;

	// configuration port
	localparam int PADDR_W = 3;
	localparam logic REG_MARKER = 1'b0;
	localparam logic [31:0] MARKER_RESET = 32'hFFFF_FFFF;

	// operation codes
	localparam logic [1:0] OP_WRITE  = 2'd0;
	localparam logic [1:0] OP_READ   = 2'd1;
	localparam logic [1:0] OP_SEARCH = 2'd2;
	localparam logic [1:0] OP_SPLIT  = 2'd3;

	// result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NONE    = 2'd1;
	localparam logic [1:0] ST_EMPTY   = 2'd2;
	localparam logic [1:0] ST_REFUSED = 2'd3;

	// input item
	typedef struct packed {
		logic [1:0]  opcode;
		logic [7:0]  position;
		logic [31:0] page_id;
	} in_item_t;

	// result item
	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] found_page;
		logic [7:0]  found_position;
	} out_item_t;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic look;
		logic load;
	} cmd_t;

endpackage

@@ hdl/bde_ctrl.sv @@
// bucket directory engine: controller state machine
// sequences capture, lookup and result load; owns the output valid flag
// depends on bde_pkg
module bde_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	output bde_pkg::cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_LOOK = 2'd1;
	localparam logic [1:0] S_LOAD = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       load_ok;
	logic       accept;

	// handshake decisions
	assign load_ok  = (state_q == S_LOAD) && (!out_valid_q || !out_stall);
	assign in_stall = !((state_q == S_IDLE) || load_ok);
	assign accept   = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	// commands to the datapath
	assign cmd.capture = accept;
	assign cmd.look    = (state_q == S_LOOK);
	assign cmd.load    = load_ok;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_LOOK;
			end
			S_LOOK: begin
				state_d = S_LOAD;
			end
			S_LOAD: begin
				if (load_ok) state_d = accept ? S_LOOK : S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_ok) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_look_then_load: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LOOK |=> state_q == S_LOAD)
		else $error("lookup not followed by load");
	a_accept_to_look: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_LOOK)
		else $error("accepted item did not enter lookup");
	a_load_gives_valid: assert property (@(posedge clk) disable iff (!arst_n)
		load_ok |=> out_valid_q)
		else $error("result load did not raise valid");
	a_valid_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_LOAD)
		else $error("valid rose outside load");
	a_accept_states: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> (state_q == S_IDLE || state_q == S_LOAD))
		else $error("input open in a busy state");
`endif

endmodule

@@ hdl/bde_datapath.sv @@
// bucket directory engine: datapath
// occupancy flops, page id memory, search and split logic, marker and result registers
// depends on bde_pkg
module bde_datapath #(
	parameter int SLOT_COUNT = bde_pkg::SLOT_COUNT_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bde_pkg::cmd_t      cmd,
	input  bde_pkg::in_item_t  in_data,
	input  logic               marker_we,
	input  logic [31:0]        marker_wdata,
	output logic [31:0]        marker,
	output bde_pkg::out_item_t out_data
);

	// only slots below 256 can be addressed, higher slots stay empty
	localparam int DEPTH = (SLOT_COUNT < 256) ? SLOT_COUNT : 256;
	localparam int AW    = $clog2(DEPTH);
	localparam int PW    = $clog2(2 * SLOT_COUNT + 256);
	localparam int NK    = $clog2(SLOT_COUNT);
	localparam logic [8:0]    DEPTH_9 = 9'(DEPTH);
	localparam logic [PW-1:0] DEPTH_W = PW'(DEPTH);
	localparam logic [PW-1:0] SLOTS_W = PW'(SLOT_COUNT);

	logic [1:0]       op_q;
	logic [7:0]       pos_q;
	logic [31:0]      pid_q;
	logic [31:0]      marker_q;
	logic [DEPTH-1:0] occ_q;
	logic [31:0]      page_mem [DEPTH];
	logic [31:0]      rdata_q;
	logic [1:0]       status_q;
	logic [31:0]      fixed_page_q;
	logic             from_mem_q;
	logic [7:0]       res_pos_q;
	bde_pkg::out_item_t out_q;

	logic          in_range;
	logic [AW-1:0] idx;
	logic [AW-1:0] start;
	logic          hit;
	logic [AW-1:0] hidx;
	logic [AW-1:0] raddr;
	logic [PW-1:0] pos_w;
	logic [PW-1:0] nb;
	logic          nb_free;
	logic [PW-1:0] target;
	logic          self_occ;
	logic          mem_we;
	logic [1:0]    status_d;
	logic [31:0]   fixed_page_d;
	logic          from_mem_d;
	logic [7:0]    res_pos_d;

	assign marker   = marker_q;
	assign out_data = out_q;

	// addressing
	assign in_range = {1'b0, pos_q} < DEPTH_9;
	assign idx      = pos_q[AW-1:0];
	assign pos_w    = PW'(pos_q);
	assign self_occ = in_range && occ_q[idx];

	// nearest occupied slot at or below the start slot
	always_comb begin
		start = in_range ? idx : AW'(DEPTH - 1);
		hit   = 1'b0;
		hidx  = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (occ_q[i] && (AW'(i) <= start)) begin
				hit  = 1'b1;
				hidx = AW'(i);
			end
		end
	end

	// split target: neighbour, then doubling probes while empty
	always_comb begin
		logic [PW-1:0] probe;
		logic          alive;
		nb      = pos_w + PW'(1);
		nb_free = (nb < SLOTS_W) && !((nb < DEPTH_W) && occ_q[nb[AW-1:0]]);
		target  = nb;
		alive   = 1'b1;
		probe   = '0;
		for (int k = 1; k <= NK; k++) begin
			probe = pos_w + (PW'(1) << k);
			alive = alive && (probe < SLOTS_W)
				&& !((probe < DEPTH_W) && occ_q[probe[AW-1:0]]);
			if (alive) target = probe;
		end
	end

	// per-operation outcome
	always_comb begin
		status_d     = bde_pkg::ST_NONE;
		fixed_page_d = marker_q;
		from_mem_d   = 1'b0;
		res_pos_d    = '0;
		mem_we       = 1'b0;
		raddr        = hidx;
		case (op_q)
			bde_pkg::OP_WRITE: begin
				if (!in_range) begin
					status_d = bde_pkg::ST_EMPTY;
				end else if (pid_q == marker_q) begin
					status_d = bde_pkg::ST_REFUSED;
				end else begin
					status_d     = bde_pkg::ST_OK;
					fixed_page_d = pid_q;
					res_pos_d    = pos_q;
					mem_we       = 1'b1;
				end
			end
			bde_pkg::OP_READ: begin
				raddr = idx;
				if (!in_range) begin
					status_d = bde_pkg::ST_EMPTY;
				end else if (occ_q[idx]) begin
					status_d   = bde_pkg::ST_OK;
					from_mem_d = 1'b1;
					res_pos_d  = pos_q;
				end
			end
			bde_pkg::OP_SEARCH: begin
				if (hit) begin
					status_d   = bde_pkg::ST_OK;
					from_mem_d = 1'b1;
					res_pos_d  = 8'(hidx);
				end
			end
			bde_pkg::OP_SPLIT: begin
				if (!self_occ) begin
					status_d = bde_pkg::ST_EMPTY;
				end else if (pos_q[0] || !nb_free) begin
					status_d = bde_pkg::ST_NONE;
				end else begin
					status_d  = bde_pkg::ST_OK;
					res_pos_d = target[7:0];
				end
			end
			default: begin
				status_d = bde_pkg::ST_NONE;
			end
		endcase
	end

	// marker register and occupancy flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_q <= bde_pkg::MARKER_RESET;
			occ_q    <= '0;
		end else begin
			if (marker_we) marker_q <= marker_wdata;
			if (cmd.look && mem_we) occ_q[idx] <= 1'b1;
		end
	end

	// page id memory, registered read
	always_ff @(posedge clk) begin
		if (cmd.look) begin
			if (mem_we) page_mem[idx] <= pid_q;
			rdata_q <= page_mem[raddr];
		end
	end

	// item capture, lookup outcome and result registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= in_data.opcode;
			pos_q <= in_data.position;
			pid_q <= in_data.page_id;
		end
		if (cmd.look) begin
			status_q     <= status_d;
			fixed_page_q <= fixed_page_d;
			from_mem_q   <= from_mem_d;
			res_pos_q    <= res_pos_d;
		end
		if (cmd.load) begin
			out_q.status         <= status_q;
			out_q.found_page     <= from_mem_q ? rdata_q : fixed_page_q;
			out_q.found_position <= res_pos_q;
		end
	end

endmodule

@@ hdl/bucket_directory_engine_top.sv @@
// bucket directory engine: top level
// ties the controller, the datapath and the configuration port together
// depends on bde_pkg, bde_ctrl, bde_datapath
//
// usage
// - input channel in_valid / in_stall / in_data carries one operation per transfer:
//   write slot, read slot, search down, split target
// - output channel out_valid / out_stall / out_data returns exactly one result
//   per input transfer, in order
// - an item is captured, looked up in the next cycle (occupancy flops searched,
//   page id memory read or written), and the result is then loaded into the output
//   register once that register is free; out_valid rises with that load, and the
//   result transfer follows when out_stall is low
// - a new item is taken in the cycle its predecessor's result is loaded, so the
//   block takes no new item while one is in lookup, a limit set by the registered
//   read of the page id memory
// - out_stall holds the result in the output register; the next item may still
//   finish lookup, then waits until the register is free, and in_stall stays high
// - reset clears every slot to empty and sets the marker to all ones;
//   no clearing pass is needed, the block is ready in the first cycle
// - the marker register sits at byte address 0 of the register port; the user
//   must write it only while the block is idle, the block does not enforce this
module bucket_directory_engine_top #(
	parameter int SLOT_COUNT = bde_pkg::SLOT_COUNT_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  bde_pkg::in_item_t             in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output bde_pkg::out_item_t            out_data,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bde_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	bde_pkg::cmd_t cmd;
	logic          marker_we;
	logic [31:0]   marker;

	// register port decode
	assign pready    = 1'b1;
	assign marker_we = psel && penable && pwrite && (paddr[2] == bde_pkg::REG_MARKER);
	assign prdata    = (paddr[2] == bde_pkg::REG_MARKER) ? marker : 32'd0;

	// controller
	bde_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// datapath
	bde_datapath #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.in_data      (in_data),
		.marker_we    (marker_we),
		.marker_wdata (pwdata),
		.marker       (marker),
		.out_data     (out_data)
	);

endmodule

@@ sim/tb_bucket_directory_engine_top.sv @@
`timescale 1ns / 1ps
// testbench for bucket_directory_engine_top: directed table, then random phases under several markers
// depends on bde_pkg and bucket_directory_engine_top
module tb_bucket_directory_engine_top;

	localparam int SLOTS = bde_pkg::SLOT_COUNT_DEFAULT;
	localparam int PHASES = 4;
	localparam int PHASE_ITEMS = 282;
	localparam int HOLD_CYCLES = 60;
	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 6;
	localparam logic [bde_pkg::PADDR_W-1:0] MARKER_ADDR =
		bde_pkg::PADDR_W'(4 * bde_pkg::REG_MARKER);

	// one row of the directed table: operation plus optional hand-written result
	typedef struct packed {
		bde_pkg::in_item_t  item;
		logic               fixed;
		bde_pkg::out_item_t result;
	} dir_row_t;

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_stall;
	bde_pkg::in_item_t           in_data;
	logic                        out_valid;
	logic                        out_stall;
	bde_pkg::out_item_t          out_data;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [bde_pkg::PADDR_W-1:0] paddr;
	logic [31:0]                 pwdata;
	logic [31:0]                 prdata;
	logic                        pready;

	// shadow directory
	logic [31:0]      dir_pages [SLOTS];
	logic [SLOTS-1:0] dir_used;
	logic [31:0]      dir_marker;
	logic [7:0]       last_written;

	bde_pkg::out_item_t expected_results[$];

	int  mismatches;
	int  results_checked;
	int  items_sent;
	int  splits_found;
	int  writes_refused;
	int  hold_reqs;
	int  hold_taken;
	logic steady;

	bucket_directory_engine_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// clock
	always #1 clk = ~clk;

	// one line per mismatch
	task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
		$display("mismatch at %0t: %s expected %0h got %0h", $time, what, want, got);
		mismatches++;
	endtask

	// directory behaviour: works out one result and updates the shadow state
	function automatic bde_pkg::out_item_t directory_predict(bde_pkg::in_item_t it);
		bde_pkg::out_item_t r;
		int p;
		int i;
		int step;
		int probe;
		int tgt;
		p = int'(it.position);
		r.status = bde_pkg::ST_OK;
		r.found_page = dir_marker;
		r.found_position = '0;
		case (it.opcode)
			bde_pkg::OP_WRITE: begin
				if (it.page_id == dir_marker) begin
					r.status = bde_pkg::ST_REFUSED;
				end else begin
					dir_pages[p] = it.page_id;
					dir_used[p] = 1'b1;
					last_written = it.position;
					r.found_page = it.page_id;
					r.found_position = it.position;
				end
			end
			bde_pkg::OP_READ: begin
				if (dir_used[p]) begin
					r.found_page = dir_pages[p];
					r.found_position = it.position;
				end else begin
					r.status = bde_pkg::ST_NONE;
				end
			end
			bde_pkg::OP_SEARCH: begin
				r.status = bde_pkg::ST_NONE;
				for (i = p; i >= 0; i--) begin
					if (dir_used[i]) begin
						r.status = bde_pkg::ST_OK;
						r.found_page = dir_pages[i];
						r.found_position = i[7:0];
						break;
					end
				end
			end
			default: begin
				// split target: even occupied slot with an empty odd neighbour
				if (!dir_used[p]) begin
					r.status = bde_pkg::ST_EMPTY;
				end else if (p[0] || p + 1 >= SLOTS || dir_used[p+1]) begin
					r.status = bde_pkg::ST_NONE;
				end else begin
					tgt = p + 1;
					step = 2;
					probe = p + step;
					while (probe < SLOTS && !dir_used[probe]) begin
						tgt = probe;
						step = step * 2;
						probe = p + step;
					end
					r.found_position = tgt[7:0];
				end
			end
		endcase
		return r;
	endfunction

	function automatic dir_row_t row(logic [1:0] op, logic [7:0] pos, logic [31:0] pid,
			logic fixed, logic [1:0] st, logic [31:0] page, logic [7:0] fpos);
		dir_row_t r;
		r.item.opcode = op;
		r.item.position = pos;
		r.item.page_id = pid;
		r.fixed = fixed;
		r.result.status = st;
		r.result.found_page = page;
		r.result.found_position = fpos;
		return r;
	endfunction

	// random operation, biased towards even slots and the last slot written
	function automatic bde_pkg::in_item_t random_item();
		bde_pkg::in_item_t it;
		int pick;
		pick = $urandom_range(99);
		it.page_id = $urandom;
		it.position = 8'($urandom_range(SLOTS - 1));
		if (pick < 20) begin
			it.opcode = bde_pkg::OP_WRITE;
			if ($urandom_range(99) < 80)
				it.position[0] = 1'b0;
			case ($urandom_range(9))
				0: it.page_id = dir_marker;
				1: it.page_id = dir_marker ^ (32'd1 << $urandom_range(31));
				default: ;
			endcase
		end else if (pick < 42) begin
			it.opcode = bde_pkg::OP_READ;
			if ($urandom_range(1))
				it.position = last_written;
		end else if (pick < 65) begin
			it.opcode = bde_pkg::OP_SEARCH;
		end else begin
			it.opcode = bde_pkg::OP_SPLIT;
			if ($urandom_range(99) < 40)
				it.position = last_written;
			else if ($urandom_range(99) < 70)
				it.position[0] = 1'b0;
		end
		return it;
	endfunction

	// offer one item, hold it until the transfer, then log its expected result
	task automatic send_item(bde_pkg::in_item_t it, logic fixed,
			bde_pkg::out_item_t fixed_result);
		bde_pkg::out_item_t pred;
		while (!steady && $urandom_range(99) < 34) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		pred = directory_predict(it);
		expected_results.push_back(fixed ? fixed_result : pred);
		items_sent++;
		if (it.opcode == bde_pkg::OP_SPLIT && pred.status == bde_pkg::ST_OK)
			splits_found++;
		if (pred.status == bde_pkg::ST_REFUSED)
			writes_refused++;
		@(negedge clk);
	endtask

	// stop offering and wait for every outstanding result
	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// register write followed by a read back
	task automatic marker_write(logic [31:0] value);
		logic [31:0] got;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= MARKER_ADDR;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		dir_marker = value;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		psel <= 1'b1;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (got !== value)
			report_mismatch("marker read back", value, got);
	endtask

	// stimulus
	initial begin
		dir_row_t rows[$];
		int ph;
		int n;
		in_valid = 1'b0;
		in_data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		arst_n = 1'b0;
		steady = 1'b0;
		hold_reqs = 0;
		dir_used = '0;
		dir_marker = bde_pkg::MARKER_RESET;
		last_written = '0;
		mismatches = 0;
		results_checked = 0;
		items_sent = 0;
		splits_found = 0;
		writes_refused = 0;

		// directed table, empty directory and reset marker
		rows.push_back(row(bde_pkg::OP_READ, 8'd0, 32'h0, 1'b1,
			bde_pkg::ST_NONE, bde_pkg::MARKER_RESET, 8'd0));
		rows.push_back(row(bde_pkg::OP_SEARCH, 8'd255, 32'h0, 1'b1,
			bde_pkg::ST_NONE, bde_pkg::MARKER_RESET, 8'd0));
		rows.push_back(row(bde_pkg::OP_SPLIT, 8'd0, 32'h0, 1'b1,
			bde_pkg::ST_EMPTY, bde_pkg::MARKER_RESET, 8'd0));
		rows.push_back(row(bde_pkg::OP_WRITE, 8'd0, bde_pkg::MARKER_RESET, 1'b1,
			bde_pkg::ST_REFUSED, bde_pkg::MARKER_RESET, 8'd0));
		rows.push_back(row(bde_pkg::OP_WRITE, 8'd0, 32'h0, 1'b1,
			bde_pkg::ST_OK, 32'h0, 8'd0));
		rows.push_back(row(bde_pkg::OP_WRITE, 8'd255, 32'hFFFF_FFFE, 1'b1,
			bde_pkg::ST_OK, 32'hFFFF_FFFE, 8'd255));
		rows.push_back(row(bde_pkg::OP_READ, 8'd0, 32'h0, 1'b1,
			bde_pkg::ST_OK, 32'h0, 8'd0));
		rows.push_back(row(bde_pkg::OP_READ, 8'd255, 32'h0, 1'b1,
			bde_pkg::ST_OK, 32'hFFFF_FFFE, 8'd255));
		rows.push_back(row(bde_pkg::OP_SEARCH, 8'd254, 32'h0, 1'b1,
			bde_pkg::ST_OK, 32'h0, 8'd0));
		rows.push_back(row(bde_pkg::OP_SEARCH, 8'd255, 32'h0, 1'b1,
			bde_pkg::ST_OK, 32'hFFFF_FFFE, 8'd255));
		// probes double out to the far end of the directory
		rows.push_back(row(bde_pkg::OP_SPLIT, 8'd0, 32'h0, 1'b0, '0, '0, '0));
		rows.push_back(row(bde_pkg::OP_SPLIT, 8'd255, 32'h0, 1'b1,
			bde_pkg::ST_NONE, bde_pkg::MARKER_RESET, 8'd0));
		rows.push_back(row(bde_pkg::OP_WRITE, 8'd1, 32'h5555_AAAA, 1'b0, '0, '0, '0));
		// occupied odd neighbour blocks the split
		rows.push_back(row(bde_pkg::OP_SPLIT, 8'd0, 32'h0, 1'b1,
			bde_pkg::ST_NONE, bde_pkg::MARKER_RESET, 8'd0));
		rows.push_back(row(bde_pkg::OP_WRITE, 8'd2, 32'hAAAA_5555, 1'b0, '0, '0, '0));
		rows.push_back(row(bde_pkg::OP_SPLIT, 8'd2, 32'h0, 1'b0, '0, '0, '0));
		rows.push_back(row(bde_pkg::OP_WRITE, 8'd4, 32'h1234_5678, 1'b0, '0, '0, '0));
		// first probe occupied, target stays on the neighbour
		rows.push_back(row(bde_pkg::OP_SPLIT, 8'd2, 32'h0, 1'b0, '0, '0, '0));
		rows.push_back(row(bde_pkg::OP_WRITE, 8'd254, 32'h8765_4321, 1'b0, '0, '0, '0));
		rows.push_back(row(bde_pkg::OP_SPLIT, 8'd254, 32'h0, 1'b1,
			bde_pkg::ST_NONE, bde_pkg::MARKER_RESET, 8'd0));
		rows.push_back(row(bde_pkg::OP_SEARCH, 8'd7, 32'hFFFF_FFFF, 1'b0, '0, '0, '0));
		rows.push_back(row(bde_pkg::OP_READ, 8'd3, 32'h0, 1'b1,
			bde_pkg::ST_NONE, bde_pkg::MARKER_RESET, 8'd0));
		rows.push_back(row(bde_pkg::OP_SPLIT, 8'd3, 32'h0, 1'b1,
			bde_pkg::ST_EMPTY, bde_pkg::MARKER_RESET, 8'd0));
		rows.push_back(row(bde_pkg::OP_SEARCH, 8'd0, 32'h0, 1'b0, '0, '0, '0));

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (rows[i])
			send_item(rows[i].item, rows[i].fixed, rows[i].result);

		// random phases, marker changed between them while idle
		for (ph = 0; ph < PHASES; ph++) begin
			if (ph != 0) begin
				drain_results();
				case (ph)
					1: marker_write(32'h0);
					2: marker_write($urandom);
					default: marker_write(bde_pkg::MARKER_RESET);
				endcase
			end
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 1 && n == 50)
					hold_reqs <= hold_reqs + 1;
				if (ph == 2 && n == 0)
					steady <= 1'b1;
				if (ph == 2 && n == 120)
					steady <= 1'b0;
				if (ph == 2 && n == 200)
					drain_results();
				send_item(random_item(), 1'b0, '0);
			end
		end

		drain_results();
		$display("covered %0d operations, %0d results checked, %0d marker settings",
			items_sent, results_checked, PHASES);
		$display("split targets found %0d, marker writes refused %0d, mismatches %0d",
			splits_found, writes_refused, mismatches);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// result side stall, with one long hold-off on request
	initial begin
		out_stall = 1'b0;
		hold_taken = 0;
		forever begin
			@(negedge clk);
			if (hold_taken != hold_reqs) begin
				hold_taken++;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				out_stall <= !steady && ($urandom_range(99) < 34);
			end
		end
	end

	// compare every result transfer with the oldest expectation
	initial begin
		bde_pkg::out_item_t want;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with nothing expected", '0, out_data.found_page);
				end else begin
					want = expected_results.pop_front();
					results_checked++;
					if (out_data.status !== want.status)
						report_mismatch("status", 32'(want.status), 32'(out_data.status));
					if (out_data.found_page !== want.found_page)
						report_mismatch("found_page", want.found_page, out_data.found_page);
					if (out_data.found_position !== want.found_position)
						report_mismatch("found_position", 32'(want.found_position),
							32'(out_data.found_position));
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
				idle = 0;
			else if (arst_n)
				idle++;
		end
		$display("watchdog: no transfer for %0d cycles", idle);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ bucket_directory_engine_top.f @@
hdl/bde_pkg.sv
hdl/bde_ctrl.sv
hdl/bde_datapath.sv
hdl/bucket_directory_engine_top.sv
sim/tb_bucket_directory_engine_top.sv
